// ===== src/cdeq_pkg.sv =====
// Shared constants and types for the circular double-ended queue.
`default_nettype none
package cdeq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 5;
    localparam int WORD_W = 32;
    localparam int OP_W = 3;
    localparam int RESET_CAP = 16;
    localparam int RESET_CAP_EFF = (RESET_CAP > DEPTH) ? DEPTH : RESET_CAP;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 72;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_REAR  = 3'd1,
        OP_REM_FRONT = 3'd2,
        OP_REM_REAR  = 3'd3,
        OP_PEEK      = 3'd4
    } op_t;

endpackage
`default_nettype wire

// ===== src/cdeq_slots.sv =====
// Slot storage: one write port and two registered read ports with write bypass.
`default_nettype none
module cdeq_slots (
    input  wire logic            aclk,
    input  wire logic            we,
    input  wire cdeq_pkg::idx_t  waddr,
    input  wire cdeq_pkg::word_t wdata,
    input  wire logic            re,
    input  wire cdeq_pkg::idx_t  raddr_a,
    input  wire cdeq_pkg::idx_t  raddr_b,
    output cdeq_pkg::word_t      rdata_a,
    output cdeq_pkg::word_t      rdata_b
);

    cdeq_pkg::word_t mem [cdeq_pkg::DEPTH];
    cdeq_pkg::word_t rdata_a_reg;
    cdeq_pkg::word_t rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a_reg <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
            rdata_b_reg <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule
`default_nettype wire

// ===== src/circular_double_ended_queue.sv =====
// Top level of the circular double-ended queue of signed 32-bit words.
// Each request inserts at the front or rear, removes from the front or rear, or
// peeks, and yields one result in the cycle after it is accepted. A request can be
// accepted every cycle as long as the result side keeps taking results; the
// index update and the single slot write take place at acceptance, and the two slot
// reads at the new front and rear are registered with the result. Writing the
// capacity empties the deque; a capacity of 0 acts as 1, and one above the built
// depth acts as the depth.
`default_nettype none
module circular_double_ended_queue (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [cdeq_pkg::CAP_W-1:0]     cfg_wr_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // operation [2:0], value [34:3], zero padding above
    input  wire logic [cdeq_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // accepted [0], front_value [32:1], rear_value [64:33], is_empty [65],
    // is_full [66], zero padding above
    output logic [cdeq_pkg::M_DATA_W-1:0]       m_tdata
);

    cdeq_pkg::idx_t cap_last_reg;
    cdeq_pkg::idx_t head_reg, head_next;
    cdeq_pkg::idx_t tail_reg, tail_next;
    cdeq_pkg::cnt_t cnt_reg, cnt_next;
    cdeq_pkg::cnt_t cap_cnt;
    cdeq_pkg::idx_t cfg_cap_last;
    logic           m_valid_reg;
    logic           ok_reg, ok_next;
    logic           empty_reg, full_reg;
    logic           accept;
    logic           full_now, empty_now;
    logic           we;
    cdeq_pkg::idx_t waddr;
    cdeq_pkg::op_t  op;
    cdeq_pkg::word_t value;
    cdeq_pkg::word_t front_rd, rear_rd;
    cdeq_pkg::word_t front_out, rear_out;

    assign op     = cdeq_pkg::op_t'(s_tdata[cdeq_pkg::OP_W-1:0]);
    assign value  = s_tdata[cdeq_pkg::OP_W +: cdeq_pkg::WORD_W];
    assign accept = s_tvalid && s_tready;
    assign s_tready = !m_valid_reg || m_tready;

    assign cap_cnt   = cdeq_pkg::CNT_W'(cap_last_reg) + cdeq_pkg::CNT_W'(1);
    assign full_now  = cnt_reg >= cap_cnt;
    assign empty_now = cnt_reg == '0;

    always_comb begin
        if (cfg_wr_data == '0) begin
            cfg_cap_last = '0;
        end else if (int'(cfg_wr_data) > cdeq_pkg::DEPTH) begin
            cfg_cap_last = cdeq_pkg::IDX_W'(cdeq_pkg::DEPTH - 1);
        end else begin
            cfg_cap_last = cdeq_pkg::IDX_W'(cfg_wr_data - cdeq_pkg::CAP_W'(1));
        end
    end

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        we        = 1'b0;
        waddr     = head_reg;
        ok_next   = 1'b0;
        case (op)
            cdeq_pkg::OP_INS_FRONT, cdeq_pkg::OP_INS_REAR: begin
                if (!full_now) begin
                    if (empty_now) begin
                        head_next = '0;
                        tail_next = '0;
                        waddr     = '0;
                    end else if (op == cdeq_pkg::OP_INS_FRONT) begin
                        head_next = (head_reg == '0) ? cap_last_reg
                                                     : head_reg - cdeq_pkg::IDX_W'(1);
                        waddr     = head_next;
                    end else begin
                        tail_next = (tail_reg >= cap_last_reg) ? '0
                                                               : tail_reg + cdeq_pkg::IDX_W'(1);
                        waddr     = tail_next;
                    end
                    cnt_next = cnt_reg + cdeq_pkg::CNT_W'(1);
                    we       = 1'b1;
                    ok_next  = 1'b1;
                end
            end
            cdeq_pkg::OP_REM_FRONT, cdeq_pkg::OP_REM_REAR: begin
                if (!empty_now) begin
                    if (cnt_reg == cdeq_pkg::CNT_W'(1)) begin
                        head_next = '0;
                        tail_next = '0;
                        cnt_next  = '0;
                    end else begin
                        if (op == cdeq_pkg::OP_REM_FRONT) begin
                            head_next = (head_reg >= cap_last_reg) ? '0
                                                                   : head_reg + cdeq_pkg::IDX_W'(1);
                        end else begin
                            tail_next = (tail_reg == '0) ? cap_last_reg
                                                         : tail_reg - cdeq_pkg::IDX_W'(1);
                        end
                        cnt_next = cnt_reg - cdeq_pkg::CNT_W'(1);
                    end
                    ok_next = 1'b1;
                end
            end
            cdeq_pkg::OP_PEEK: begin
                ok_next = 1'b1;
            end
            default: begin
                ok_next = 1'b0;
            end
        endcase
    end

    cdeq_slots u_slots (
        .aclk    (aclk),
        .we      (accept && we),
        .waddr   (waddr),
        .wdata   (value),
        .re      (accept),
        .raddr_a (head_next),
        .raddr_b (tail_next),
        .rdata_a (front_rd),
        .rdata_b (rear_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_last_reg <= cdeq_pkg::IDX_W'(cdeq_pkg::RESET_CAP_EFF - 1);
            head_reg     <= '0;
            tail_reg     <= '0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_last_reg <= cfg_cap_last;
                head_reg     <= '0;
                tail_reg     <= '0;
                cnt_reg      <= '0;
            end else if (accept) begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                cnt_reg  <= cnt_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ok_reg    <= ok_next;
            empty_reg <= cnt_next == '0;
            full_reg  <= cnt_next >= cap_cnt;
        end
    end

    assign front_out = empty_reg ? '1 : front_rd;
    assign rear_out  = empty_reg ? '1 : rear_rd;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(cdeq_pkg::M_DATA_W - 2 * cdeq_pkg::WORD_W - 3){1'b0}},
                       full_reg, empty_reg, rear_out, front_out, ok_reg};

endmodule
`default_nettype wire
